// File: rtl/core/tsa_pkg.sv
// Shared types and constants of the temperature sample averager.
package tsa_pkg;

    localparam int RING_DEPTH = 8;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int AVG_SHIFT = $clog2(RING_DEPTH + 1) - 1;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int TEMP_W = 11;

    localparam int TEMP_SCALE = 1000;
    localparam int TEMP_SLOPE = 5336;
    localparam int TEMP_OFFSET = 30;
    localparam int SCALE_RED = TEMP_SCALE / 8;
    localparam int SLOPE_RED = TEMP_SLOPE / 8;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP = ((2 ** RECIP_SHIFT) + SLOPE_RED - 1) / SLOPE_RED;
    localparam int MAG_W = 19;
    localparam int RECIP_W = 20;
    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int QUOT_W = 10;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [SAMPLE_W-1:0] sample;
    } cmd_word_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [SAMPLE_W-1:0]      average_raw;
    } res_word_t;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
    } ring_req_t;

endpackage

// File: rtl/core/tsa_ring.sv
// Sample ring memory with a registered read port and per-entry valid bits.
module tsa_ring (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsa_pkg::ring_req_t           req,
    output logic [tsa_pkg::SAMPLE_W-1:0] rd_data
);
    import tsa_pkg::*;

    logic [SAMPLE_W-1:0]   mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] valid_reg;
    logic [SAMPLE_W-1:0]   mem_q_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_data = rd_valid_reg ? mem_q_reg : '0;

endmodule

// File: rtl/core/tsa_celsius.sv
// Three-stage conversion of the ring average into degrees Celsius.
module tsa_celsius (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tsa_pkg::SAMPLE_W-1:0]        avg,
    input  logic [tsa_pkg::SAMPLE_W-1:0]        cal,
    output logic                                done,
    output logic signed [tsa_pkg::TEMP_W-1:0]   temperature
);
    import tsa_pkg::*;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-1:0]      mag;
    logic [QUOT_W-1:0]        quot;
    logic [TEMP_W-1:0]        quot_ext;
    logic [TEMP_W-1:0]        temp_next;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 done_reg;
    logic                 s1_neg_reg;
    logic                 s2_neg_reg;
    logic [MAG_W-1:0]     s1_mag_reg;
    logic [PROD_W-1:0]    s2_prod_reg;
    logic [TEMP_W-1:0]    temp_reg;

    assign diff = $signed({1'b0, cal}) - $signed({1'b0, avg});
    assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

    // The quotient is rounded down by a reciprocal that is exact over the magnitude range.
    assign quot     = s2_prod_reg[PROD_W-1 -: QUOT_W];
    assign quot_ext = {{(TEMP_W - QUOT_W){1'b0}}, quot};
    assign temp_next = s2_neg_reg ? TEMP_W'(TEMP_OFFSET) - quot_ext
                                  : TEMP_W'(TEMP_OFFSET) + quot_ext;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_neg_reg <= diff[SAMPLE_W];
            s1_mag_reg <= {{(MAG_W - SAMPLE_W){1'b0}}, mag} * MAG_W'(SCALE_RED);
        end
        if (s1_valid_reg)
        begin
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= {{RECIP_W{1'b0}}, s1_mag_reg} * {{MAG_W{1'b0}}, RECIP_W'(RECIP)};
        end
        if (s2_valid_reg)
        begin
            temp_reg <= temp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    assign done        = done_reg;
    assign temperature = $signed(temp_reg);

endmodule

// File: rtl/core/temperature_sample_averager.sv
// Top level of the temperature sample averager: command sequencer, ring and result register.
//
//   channel   direction   handshake              word
//   cmd       in          cmd_valid / cmd_stall  cmd_word (command, sample)
//   res       out         res_valid / res_stall  res_word (temperature, average_raw)
//   cfg       in          cfg_wr_en              cfg_wr_data (cal_value)
//
// A store is one ring write from idle, and a fill writes all RING_DEPTH entries, one ring write per cycle.
// A read with a fresh sample first runs a serial sum over the single ring read port
// and then the conversion; a read of the cached average goes straight to the conversion.
// Reset clears the ring through per-entry valid bits, so no clearing pass is needed.
// A waiting result does not block stores or fills; a new read waits for the result register.
module temperature_sample_averager (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  tsa_pkg::cmd_word_t         cmd_word,
    output logic                       res_valid,
    input  logic                       res_stall,
    output tsa_pkg::res_word_t         res_word,
    input  logic                       cfg_wr_en,
    input  logic [tsa_pkg::SAMPLE_W-1:0] cfg_wr_data
);
    import tsa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_CONV = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    widx_reg, widx_next;
    logic                fresh_reg, fresh_next;
    logic [SAMPLE_W-1:0] cached_reg, cached_next;
    logic [SAMPLE_W-1:0] cal_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_last_reg, rd_last_next;
    logic [SAMPLE_W-1:0] fill_reg, fill_next;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_word_reg, res_word_next;

    ring_req_t           ring_req;
    logic [SAMPLE_W-1:0] ring_data;
    logic                conv_start;
    logic                conv_done;
    logic signed [TEMP_W-1:0] conv_temp;
    logic                accept;
    logic [SUM_W-1:0]    total;
    logic [SUM_W-1:0]    shifted;
    logic [SAMPLE_W-1:0] mean;
    logic                out_free;

    tsa_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .rd_data (ring_data)
    );

    tsa_celsius u_celsius (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (conv_start),
        .avg         (cached_next),
        .cal         (cal_reg),
        .done        (conv_done),
        .temperature (conv_temp)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    assign total   = acc_reg + {{(SUM_W - SAMPLE_W){1'b0}}, ring_data};
    assign shifted = total >> AVG_SHIFT;
    assign mean    = (shifted > SUM_W'((2 ** SAMPLE_W) - 1)) ? '1 : shifted[SAMPLE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        fresh_next     = fresh_reg;
        cached_next    = cached_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        rd_pend_next   = 1'b0;
        rd_last_next   = 1'b0;
        conv_start     = 1'b0;
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;
        ring_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_word.command)
                        CMD_STORE:
                        begin
                            ring_req.wr_en   = 1'b1;
                            ring_req.wr_addr = widx_reg;
                            ring_req.wr_data = cmd_word.sample;
                            widx_next = (widx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                            : widx_reg + 1'b1;
                            fresh_next = 1'b1;
                        end
                        CMD_READ:
                        begin
                            cnt_next = '0;
                            acc_next = '0;
                            if (fresh_reg)
                            begin
                                fresh_next = 1'b0;
                                state_next = ST_SUM;
                            end
                            else
                            begin
                                conv_start = 1'b1;
                                state_next = ST_CONV;
                            end
                        end
                        CMD_FILL:
                        begin
                            cnt_next   = '0;
                            fill_next  = cmd_word.sample;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                ring_req.wr_en   = 1'b1;
                ring_req.wr_addr = cnt_reg[IDX_W-1:0];
                ring_req.wr_data = fill_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RING_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (cnt_reg < CNT_W'(RING_DEPTH))
                begin
                    ring_req.rd_en   = 1'b1;
                    ring_req.rd_addr = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (cnt_reg == CNT_W'(RING_DEPTH - 1));
                end
                if (rd_pend_reg)
                begin
                    acc_next = total;
                end
                if (rd_last_reg)
                begin
                    cached_next = mean;
                    conv_start  = 1'b1;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next            = 1'b1;
                    res_word_next.temperature = conv_temp;
                    res_word_next.average_raw = cached_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= '0;
            fresh_reg     <= 1'b0;
            cached_reg    <= '0;
            cal_reg       <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            fresh_reg     <= fresh_next;
            cached_reg    <= cached_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                cal_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        fill_reg     <= fill_next;
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef NO_ASSERTIONS
    a_res_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_OUT))
        else $error("Result word appeared without a finished conversion.");

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONV))
        else $error("Conversion finished outside the conversion state.");

    a_sum_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && rd_last_reg) |=> (state_reg == ST_CONV))
        else $error("Ring sum did not hand over to the conversion.");

    a_no_write_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> !ring_req.wr_en)
        else $error("Ring written while the sum is running.");
`endif

endmodule

// File: bench/tsa_result_checker.sv
// Checker for the temperature sample averager: tracks the ring, predicts and compares words.
module tsa_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  tsa_pkg::cmd_word_t            cmd_word,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  tsa_pkg::res_word_t            res_word,
    input  logic                          cfg_wr_en,
    input  logic [tsa_pkg::SAMPLE_W-1:0]  cfg_wr_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int DEPTH = tsa_pkg::RING_DEPTH;
    localparam int SCALE = 1000;
    localparam int SLOPE = 5336;
    localparam int OFFSET = 30;
    localparam int MAX_MEAN = 4095;
    localparam int REPORT_LIMIT = 10;

    logic [tsa_pkg::SAMPLE_W-1:0] ring_copy [DEPTH];
    int unsigned                  store_slot;
    logic                         fresh_sample;
    logic [tsa_pkg::SAMPLE_W-1:0] mean_cache;
    logic [tsa_pkg::SAMPLE_W-1:0] cal_copy;
    tsa_pkg::res_word_t           expected_words [$];
    int                           mismatches;

    initial begin
        fail_count = 0;
        pending = 0;
        mismatches = 0;
    end

    function automatic int unsigned mean_shift();
        int unsigned shift;
        int unsigned span;
        shift = 0;
        span = DEPTH;
        while (span > 1) begin
            span = span >> 1;
            shift++;
        end
        return shift;
    endfunction

    function automatic logic [tsa_pkg::SAMPLE_W-1:0] ring_mean();
        int unsigned total;
        total = 0;
        for (int i = 0; i < DEPTH; i++) begin
            total += ring_copy[i];
        end
        total = total >> mean_shift();
        if (total > MAX_MEAN) begin
            total = MAX_MEAN;
        end
        return total[tsa_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic tsa_pkg::res_word_t read_result();
        tsa_pkg::res_word_t word;
        int cal_level;
        int mean_level;
        int degrees;
        if (fresh_sample) begin
            mean_cache = ring_mean();
            fresh_sample = 1'b0;
        end
        cal_level = cal_copy;
        mean_level = mean_cache;
        degrees = ((cal_level - mean_level) * SCALE) / SLOPE + OFFSET;
        word.temperature = degrees[tsa_pkg::TEMP_W-1:0];
        word.average_raw = mean_cache;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n) begin : observe
        tsa_pkg::res_word_t want;
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                ring_copy[i] = '0;
            end
            store_slot = 0;
            fresh_sample = 1'b0;
            mean_cache = '0;
            cal_copy = '0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                cal_copy = cfg_wr_data;
            end
            if (cmd_valid && !cmd_stall) begin
                case (cmd_word.command)
                    tsa_pkg::CMD_STORE: begin
                        ring_copy[store_slot] = cmd_word.sample;
                        store_slot = (store_slot + 1 == DEPTH) ? 0 : store_slot + 1;
                        fresh_sample = 1'b1;
                    end
                    tsa_pkg::CMD_READ: begin
                        expected_words.push_back(read_result());
                    end
                    tsa_pkg::CMD_FILL: begin
                        for (int i = 0; i < DEPTH; i++) begin
                            ring_copy[i] = cmd_word.sample;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (res_valid && !res_stall) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Unexpected result word: temperature %0d average %0d",
                                 res_word.temperature, res_word.average_raw);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (res_word.temperature !== want.temperature ||
                        res_word.average_raw !== want.average_raw) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display({"Result mismatch: expected temperature %0d average %0d,",
                                      " got temperature %0d average %0d"},
                                     want.temperature, want.average_raw,
                                     res_word.temperature, res_word.average_raw);
                        end
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending <= expected_words.size();
    end

endmodule

// File: bench/tb_temperature_sample_averager.sv
// Testbench top for the temperature sample averager: clock, reset, stimulus, receiver and verdict.
module tb_temperature_sample_averager;

    localparam int TOTAL_WORDS = 950;
    localparam int QUIET_WORDS = 120;
    localparam int SETTLE_CYCLES = 2 * tsa_pkg::RING_DEPTH + 8;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [tsa_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 12'hfff;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_stall;
    tsa_pkg::cmd_word_t            cmd_word = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    tsa_pkg::res_word_t            res_word;
    logic                          cfg_wr_en = 1'b0;
    logic [tsa_pkg::SAMPLE_W-1:0]  cfg_wr_data = '0;
    int                            fail_count;
    int                            pending;

    int idle_pct = 0;
    int stall_pct = 0;
    bit quiet = 1'b0;
    bit hold_armed = 1'b0;
    int counted = 0;
    int cycle_count = 0;

    temperature_sample_averager uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word(cmd_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    tsa_result_checker result_check (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word(cmd_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [tsa_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return SAMPLE_MAX;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [tsa_pkg::SAMPLE_W-1:0] pick_cal();
        case ($urandom_range(3))
            0: return '0;
            1: return SAMPLE_MAX;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic issue(input logic [1:0] command, input logic [tsa_pkg::SAMPLE_W-1:0] sample);
        tsa_pkg::cmd_word_t word;
        word.command = command;
        word.sample = sample;
        if (counted >= TOTAL_WORDS - QUIET_WORDS) begin
            quiet = 1'b1;
        end
        if (!quiet && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word <= word;
        @(posedge clk);
        while (cmd_stall) begin
            @(posedge clk);
        end
        if (command != CMD_UNUSED) begin
            counted++;
        end
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_cal(input logic [tsa_pkg::SAMPLE_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            repeat ($urandom_range(1, 10)) issue(tsa_pkg::CMD_STORE, pick_sample());
            issue(tsa_pkg::CMD_READ, pick_sample());
            if ($urandom_range(3) == 0) begin
                issue(tsa_pkg::CMD_READ, pick_sample());
            end
        end else if (pick < 72) begin
            issue(tsa_pkg::CMD_FILL, pick_sample());
            if ($urandom_range(1) == 1) begin
                issue(tsa_pkg::CMD_STORE, pick_sample());
            end
            issue(tsa_pkg::CMD_READ, pick_sample());
        end else if (pick < 84) begin
            issue(tsa_pkg::CMD_READ, pick_sample());
        end else if (pick < 92) begin
            issue(CMD_UNUSED, pick_sample());
        end else begin
            issue(tsa_pkg::CMD_STORE, pick_sample());
        end
    endtask

    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_stall <= 1'b0;
            end else if (!quiet && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first read sees the reset cached average and the reset calibration.
        issue(tsa_pkg::CMD_READ, '0);
        issue(CMD_UNUSED, SAMPLE_MAX);
        issue(tsa_pkg::CMD_STORE, SAMPLE_MAX);
        issue(tsa_pkg::CMD_READ, '0);
        // A fill alone leaves the cached average in place.
        issue(tsa_pkg::CMD_FILL, SAMPLE_MAX);
        issue(tsa_pkg::CMD_READ, '0);
        issue(tsa_pkg::CMD_STORE, SAMPLE_MAX);
        issue(tsa_pkg::CMD_READ, '0);
        issue(tsa_pkg::CMD_READ, SAMPLE_MAX);
        set_cal(SAMPLE_MAX);
        issue(tsa_pkg::CMD_READ, '0);
        set_cal('0);
        issue(tsa_pkg::CMD_READ, '0);
        issue(tsa_pkg::CMD_FILL, '0);
        issue(tsa_pkg::CMD_STORE, '0);
        set_cal(SAMPLE_MAX);
        issue(tsa_pkg::CMD_READ, '0);
        set_cal(12'h800);
        for (int i = 0; i < tsa_pkg::RING_DEPTH; i++) begin
            issue(tsa_pkg::CMD_STORE, (i % 2 == 0) ? 12'haaa : 12'h555);
        end
        issue(tsa_pkg::CMD_READ, '0);

        phase = 0;
        while (counted < TOTAL_WORDS) begin
            set_cal(pick_cal());
            idle_pct = pick_pct();
            stall_pct = pick_pct();
            if (phase == 1) begin
                // The receiver holds off while reads keep coming, so the command side backs up.
                hold_armed = 1'b1;
                repeat (12) begin
                    issue(tsa_pkg::CMD_STORE, pick_sample());
                    issue(tsa_pkg::CMD_READ, pick_sample());
                end
            end
            phase_end = counted + $urandom_range(60, 120);
            while (counted < phase_end && counted < TOTAL_WORDS) begin
                random_sequence();
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
